FILE: design/depth_preferred_hash_table_defines.svh
// Assertion macros for the depth-preferred hash table.
// Used by the top level; no other dependencies.
`ifndef DEPTH_PREFERRED_HASH_TABLE_DEFINES_SVH
`define DEPTH_PREFERRED_HASH_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define DPH_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hash table assertion failed");
`define DPH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hash table assertion failed");
`else
`define DPH_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define DPH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/dph_pkg.sv
// Shared types and constants for the depth-preferred hash table.
// No dependencies; used by every module of the block.
`default_nettype none

package dph_pkg;

    localparam int DPH_TABLE_ENTRIES = 1024;
    localparam int DPH_HASH_W        = 64;
    // remainder bits retired per cycle for non power-of-two tables
    localparam int DPH_MOD_STEP_BITS = 4;

    localparam logic signed [7:0] DEPTH_EMPTY = -8'sd1;
    localparam logic signed [7:0] MOVE_NONE   = -8'sd1;
    localparam logic [31:0]       HIT_MAX     = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_LOOKUP        = 2'd0,
        CMD_INSERT_COND   = 2'd1,
        CMD_INSERT_ALWAYS = 2'd2,
        CMD_CLEAR         = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]            command;
        logic [DPH_HASH_W-1:0] hash;
        logic [6:0]            depth;
        logic signed [31:0]    score;
        logic [1:0]            bound_type;
        logic signed [7:0]     move_sq;
        logic [7:0]            iteration;
    } cmd_item_t;

    typedef struct packed {
        logic               hit;
        logic               written;
        logic signed [31:0] found_score;
        logic [1:0]         found_type;
        logic signed [7:0]  found_depth;
        logic signed [7:0]  found_move;
        logic [7:0]         found_iteration;
        logic [31:0]        hit_count;
    } res_item_t;

    typedef struct packed {
        logic [DPH_HASH_W-1:0] key;
        logic signed [7:0]     depth;
        logic signed [31:0]    score;
        logic [1:0]            bound_type;
        logic signed [7:0]     move_sq;
        logic [7:0]            iteration;
    } entry_t;

endpackage

`default_nettype wire

FILE: design/dph_index.sv
// Entry index unit: hash modulo table size.
// Depends on dph_pkg. Mask for power-of-two sizes, iterative remainder otherwise.
`default_nettype none

module dph_index #(
    parameter int TABLE_ENTRIES = dph_pkg::DPH_TABLE_ENTRIES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [dph_pkg::DPH_HASH_W-1:0]     hash,
    output logic [$clog2(TABLE_ENTRIES)-1:0]   idx,
    output logic                               done
);
    import dph_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;

    generate
        if (IS_POW2) begin : g_mask
            logic [IDX_W-1:0] idx_reg;
            logic             done_reg;

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    idx_reg <= hash[IDX_W-1:0];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else if (start)
                begin
                    done_reg <= 1'b1;
                end
            end

            assign idx  = idx_reg;
            assign done = done_reg;
        end
        else begin : g_rem
            localparam int STEPS = DPH_HASH_W / DPH_MOD_STEP_BITS;
            localparam int CNT_W = $clog2(STEPS);
            localparam logic [IDX_W:0] MODULUS = (IDX_W + 1)'(TABLE_ENTRIES);

            logic [IDX_W-1:0]      rem_reg, rem_next;
            logic [DPH_HASH_W-1:0] sh_reg;
            logic [CNT_W-1:0]      cnt_reg;
            logic                  busy_reg;

            // restoring remainder, MSB first, a few bits per cycle
            always_comb
            begin
                logic [IDX_W:0] t;
                rem_next = rem_reg;
                t        = '0;
                for (int k = 0; k < DPH_MOD_STEP_BITS; k++)
                begin
                    t = {rem_next, sh_reg[DPH_HASH_W-1-k]};
                    if (t >= MODULUS)
                    begin
                        t = t - MODULUS;
                    end
                    rem_next = t[IDX_W-1:0];
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    rem_reg <= '0;
                    sh_reg  <= hash;
                end
                else if (busy_reg)
                begin
                    rem_reg <= rem_next;
                    sh_reg  <= sh_reg << DPH_MOD_STEP_BITS;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    cnt_reg  <= '0;
                end
                else if (start)
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= '0;
                end
                else if (busy_reg)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(STEPS - 1))
                    begin
                        busy_reg <= 1'b0;
                    end
                end
            end

            assign idx  = rem_reg;
            assign done = !busy_reg;
        end
    endgenerate

endmodule

`default_nettype wire

FILE: design/dph_mem.sv
// Entry store: one write port, one read port, registered read data.
// Depends on dph_pkg for the entry layout.
`default_nettype none

module dph_mem #(
    parameter int TABLE_ENTRIES = dph_pkg::DPH_TABLE_ENTRIES
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] waddr,
    input  dph_pkg::entry_t                  wdata,
    input  logic                             re,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] raddr,
    output dph_pkg::entry_t                  rdata
);
    import dph_pkg::*;

    entry_t mem_reg [TABLE_ENTRIES];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: design/depth_preferred_hash_table.sv
// Channel   Handshake              Payload
// request   cmd_valid/cmd_ready    cmd_data (dph_pkg::cmd_item_t)
// result    res_valid/res_ready    res_data (dph_pkg::res_item_t)
//
// Lookup/insert: for power-of-two TABLE_ENTRIES a request steps through accept, index +
// memory read, evaluate + write back; other sizes wait on the remainder unit in the index step.
// Clear: sweeps the entry memory, one entry per cycle.
// After reset the same sweep runs with cmd_ready low.
// A new request is taken while a result waits in the output register; a stalled
// result holds the block in its evaluate step.
//
// Depends on dph_pkg, dph_index, dph_mem and the assertion macro header.
`default_nettype none
`include "depth_preferred_hash_table_defines.svh"

module depth_preferred_hash_table #(
    parameter int TABLE_ENTRIES = dph_pkg::DPH_TABLE_ENTRIES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  dph_pkg::cmd_item_t  cmd_data,
    output logic                res_valid,
    input  logic                res_ready,
    output dph_pkg::res_item_t  res_data
);
    import dph_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_INDEX = 4'b0100,
        ST_EVAL  = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic             clr_pending_reg, clr_pending_next;
    logic [31:0]      hit_cnt_reg, hit_cnt_next;
    logic             res_valid_reg, res_valid_next;
    res_item_t        res_data_reg, res_data_next;
    cmd_item_t        item_reg;

    logic             accept;
    logic             out_free;
    logic             eval_go;
    logic [IDX_W-1:0] idx;
    logic             idx_done;
    logic             mem_we, mem_re;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata, ent;
    logic signed [7:0] dep_s;
    logic             is_hit, do_write;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    assign out_free  = !res_valid_reg || res_ready;
    assign eval_go   = (state_reg == ST_EVAL) && out_free;
    assign dep_s     = $signed({1'b0, item_reg.depth});

    dph_index #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_index (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .hash  (cmd_data.hash),
        .idx   (idx),
        .done  (idx_done)
    );

    dph_mem #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (idx),
        .rdata (ent)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= cmd_data;
        end
        res_data_reg <= res_data_next;
    end

    // command decode against the stored entry
    always_comb
    begin
        is_hit   = 1'b0;
        do_write = 1'b0;
        unique case (item_reg.command)
            CMD_LOOKUP:        is_hit   = (ent.key == item_reg.hash) && (ent.depth >= dep_s);
            CMD_INSERT_COND:   do_write = !(ent.depth > dep_s);
            CMD_INSERT_ALWAYS: do_write = 1'b1;
            CMD_CLEAR:         ;
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        clr_pending_next = clr_pending_reg;
        hit_cnt_next     = hit_cnt_reg;
        res_valid_next   = res_valid_reg && !res_ready;
        res_data_next    = res_data_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_waddr        = idx;
        mem_wdata        = '{key: item_reg.hash, depth: dep_s, score: item_reg.score,
                             bound_type: item_reg.bound_type,
                             move_sq: item_reg.move_sq,
                             iteration: item_reg.iteration};

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '{key: '0, depth: DEPTH_EMPTY, score: '0,
                                 bound_type: '0, move_sq: '0, iteration: '0};
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(TABLE_ENTRIES - 1))
                begin
                    clr_cnt_next     = '0;
                    clr_pending_next = 1'b0;
                    state_next       = clr_pending_reg ? ST_EVAL : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_INDEX;
                end
            end
            ST_INDEX:
            begin
                if (idx_done)
                begin
                    if (item_reg.command == CMD_CLEAR)
                    begin
                        clr_cnt_next     = '0;
                        clr_pending_next = 1'b1;
                        state_next       = ST_CLEAR;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_EVAL:
            begin
                if (out_free)
                begin
                    mem_we = do_write;
                    if (item_reg.command == CMD_CLEAR)
                    begin
                        hit_cnt_next = '0;
                    end
                    else if (is_hit && (hit_cnt_reg != HIT_MAX))
                    begin
                        hit_cnt_next = hit_cnt_reg + 32'd1;
                    end
                    res_valid_next = 1'b1;
                    res_data_next  = '{
                        hit:             is_hit,
                        written:         do_write,
                        found_score:     is_hit ? ent.score : 32'sd0,
                        found_type:      is_hit ? ent.bound_type : 2'd0,
                        found_depth:     is_hit ? ent.depth : DEPTH_EMPTY,
                        found_move:      is_hit ? ent.move_sq : MOVE_NONE,
                        found_iteration: is_hit ? ent.iteration : 8'd0,
                        hit_count:       hit_cnt_next
                    };
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            clr_pending_reg <= 1'b0;
            hit_cnt_reg     <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            clr_pending_reg <= clr_pending_next;
            hit_cnt_reg     <= hit_cnt_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // an evaluated request always lands in the output register
    `DPH_ASSERT_NEXT(a_eval_result, clk, rst_n, eval_go, res_valid_reg && state_reg == ST_IDLE)
    // hit counter only moves when a request is evaluated
    `DPH_ASSERT_NEXT(a_cnt_hold, clk, rst_n, state_reg != ST_EVAL, $stable(hit_cnt_reg))
    // one request in flight at a time
    `DPH_ASSERT_NEXT(a_single_req, clk, rst_n, accept, !cmd_ready && state_reg == ST_INDEX)

endmodule

`default_nettype wire
